// ===== rtl/core/bbtb_pkg.sv =====
// Shared types, constants and the branch word decoder for the banked BTB.
// Used by bbtb_lane and the top level in rtl/core; depends on nothing.
`default_nettype none
package bbtb_pkg;

	localparam int DEF_BANKS = 8;
	localparam int DEF_SETS  = 64;
	localparam int DEF_ASSOC = 4;
	localparam int WADDR_W   = 62;

	localparam logic [1:0] CMD_LOOKUP  = 2'd0;
	localparam logic [1:0] CMD_INSTALL = 2'd1;
	localparam logic [1:0] CMD_INVAL   = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	localparam logic [2:0] KIND_COND  = 3'd0;
	localparam logic [2:0] KIND_JUMP  = 3'd1;
	localparam logic [2:0] KIND_CALL  = 3'd2;
	localparam logic [2:0] KIND_IJUMP = 3'd3;
	localparam logic [2:0] KIND_ICALL = 3'd4;
	localparam logic [2:0] KIND_RET   = 3'd5;

	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;

	typedef struct packed {
		logic        hit;
		logic [2:0]  kind;
		logic [63:0] target;
	} lane_res_t;

	typedef struct packed {
		logic        ok;
		logic        jalr;
		logic [2:0]  kind;
		logic [63:0] target;
	} dec_t;

	function automatic dec_t decode(input logic [31:0] w, input logic [63:0] pc);
		dec_t d;
		logic [63:0] imm;
		d = '0;
		imm = '0;
		case (w[6:0])
			OPC_BRANCH: begin
				imm = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				d.ok = 1'b1;
				d.kind = KIND_COND;
				d.target = pc + imm;
			end
			OPC_JAL: begin
				imm = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				d.ok = 1'b1;
				d.kind = (w[11:7] == 5'd1) ? KIND_CALL : KIND_JUMP;
				d.target = pc + imm;
			end
			OPC_JALR: begin
				d.ok = 1'b1;
				d.jalr = 1'b1;
				if (w[11:7] == 5'd0 && w[19:15] == 5'd1) d.kind = KIND_RET;
				else d.kind = (w[11:7] == 5'd1) ? KIND_ICALL : KIND_IJUMP;
			end
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bbtb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbtb_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                          wdata,
	input  wire logic                                  re,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                          rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/bbtb_lane.sv =====
// One bank lane: tag match, LRU pick and the next row for touch, clear, install.
// Depends on bbtb_pkg.
`default_nettype none
module bbtb_lane #(
	parameter int ASSOC = bbtb_pkg::DEF_ASSOC,
	parameter int TW    = 53
) (
	input  wire logic [ASSOC*(1+((ASSOC > 1) ? $clog2(ASSOC) : 1)+TW+3+64)-1:0] row,
	input  wire logic [TW-1:0]                                                   tag,
	input  wire logic [2:0]                                                      ins_kind,
	input  wire logic [63:0]                                                     ins_target,
	output bbtb_pkg::lane_res_t                                                  res,
	output logic [ASSOC*(1+((ASSOC > 1) ? $clog2(ASSOC) : 1)+TW+3+64)-1:0]       row_touch,
	output logic [ASSOC*(1+((ASSOC > 1) ? $clog2(ASSOC) : 1)+TW+3+64)-1:0]       row_clear,
	output logic [ASSOC*(1+((ASSOC > 1) ? $clog2(ASSOC) : 1)+TW+3+64)-1:0]       row_ins
);
	localparam int AW = (ASSOC > 1) ? $clog2(ASSOC) : 1;
	localparam int EW = 1 + AW + TW + 3 + 64;
	localparam int OA = 1;
	localparam int OT = 1 + AW;
	localparam int OK = 1 + AW + TW;
	localparam int OG = 1 + AW + TW + 3;

	logic          hit;
	logic [AW-1:0] hway, lru, way, a;

	always_comb begin
		hit = 1'b0;
		hway = '0;
		lru = '0;
		for (int i = 0; i < ASSOC; i++) begin
			if (!hit && row[i*EW] && row[i*EW+OT +: TW] == tag) begin
				hit = 1'b1;
				hway = AW'(i);
			end
			if (row[i*EW+OA +: AW] == AW'(ASSOC-1)) lru = AW'(i);
		end
		way = hit ? hway : lru;
		a = row[way*EW+OA +: AW];
	end

	always_comb begin
		res.hit = hit;
		res.kind = row[way*EW+OK +: 3];
		res.target = row[way*EW+OG +: 64];
	end

	always_comb begin
		row_touch = row;
		row_clear = row;
		for (int i = 0; i < ASSOC; i++) begin
			if (row[i*EW+OA +: AW] < a) row_touch[i*EW+OA +: AW] = row[i*EW+OA +: AW] + 1'b1;
			if (row[i*EW+OA +: AW] > a) row_clear[i*EW+OA +: AW] = row[i*EW+OA +: AW] - 1'b1;
		end
		row_touch[way*EW+OA +: AW] = '0;
		row_clear[way*EW+OA +: AW] = AW'(ASSOC-1);
		row_clear[way*EW] = 1'b0;
		row_ins = row_touch;
		row_ins[way*EW] = 1'b1;
		row_ins[way*EW+OT +: TW] = tag;
		row_ins[way*EW+OK +: 3] = ins_kind;
		row_ins[way*EW+OG +: 64] = ins_target;
	end
endmodule
`default_nettype wire

// ===== rtl/core/banked_branch_target_buffer.sv =====
// Banked set-associative branch target buffer: top level, lanes and bank RAMs.
// Depends on bbtb_pkg, bbtb_lane and bbtb_ram.
//
// Usage: items enter on s_* (s_tuser = command, s_tdata = operands) and
// results leave on m_* (m_tlast marks the final result of an item).
// Register max_cond_branches sits at APB byte address 0.
// Each bank is one lane with its own RAM; a lookup reads all banks in
// parallel and the merge stage walks the bundle slots one per cycle.
// Steps: accept, address, RAM read, then one result per cycle while
// m_tready allows; the first result is registered in the run state.
// Lookup: a result per slot, up to BANKS; install or invalidate: one.
// One item is worked at a time; s_tready is high only while idle.
// The output register frees the input side while a result waits.
// Reset: a clearing pass writes every row of every bank in turn
// (no valid entries, ages in way order); s_tready stays low meanwhile.
// When m_tready is low the current result holds and the walk pauses.
`default_nettype none
module banked_branch_target_buffer #(
	parameter int BANKS = bbtb_pkg::DEF_BANKS,
	parameter int SETS  = bbtb_pkg::DEF_SETS,
	parameter int ASSOC = bbtb_pkg::DEF_ASSOC
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// start_pc, slot_index, insn_word, cond_predictions, indirect_target,
	// return_target, exception_mask, zero pad
	input  wire logic [303:0] s_tdata,
	// cmd
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// slot_pc, is_branch, branch_kind, stored_target, slot_next_pc, cond_count,
	// push_return, push_address, pop_return, error_flag, zero pad
	output logic [271:0]      m_tdata,
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int LB  = (BANKS > 1) ? $clog2(BANKS) : 0;
	localparam int LS  = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int BIW = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int CW  = $clog2(SETS + 1);
	localparam int AW  = (ASSOC > 1) ? $clog2(ASSOC) : 1;
	localparam int TW  = bbtb_pkg::WADDR_W - LB - LS;
	localparam int EW  = 1 + AW + TW + 3 + 64;
	localparam int RW  = ASSOC * EW;
	localparam int WW  = bbtb_pkg::WADDR_W;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_ADDR  = 5'b00100,
		ST_READ  = 5'b01000,
		ST_RUN   = 5'b10000
	} state_t;

	state_t         state_q;
	logic [5:0]     cap_q;
	logic [1:0]     cmd_q;
	logic [63:0]    pc_q, preds_q, ind_q, ret_q, spc_q, paddr_q;
	logic [2:0]     pos_q;
	logic [31:0]    insn_q;
	logic [15:0]    exc_q;
	logic [WW-1:0]  w_s1 [BANKS];
	logic [BIW-1:0] b0_q, p_q, sel;
	logic [4:0]     ncond_q, ncond_n;
	logic           push_q, pop_q, push_n, pop_n;
	logic [63:0]    paddr_n, next_pc;
	logic [CW-1:0]  clr_q;
	logic           ov_q, fire, done, dup, wr_ok;
	logic [271:0]   od_q, od_n;
	logic           ol_q;
	logic [WW-1:0]  w0, ws;
	logic [RW-1:0]  init_row;

	logic [RW-1:0]       rdata [BANKS];
	logic [RW-1:0]       r_touch [BANKS];
	logic [RW-1:0]       r_clear [BANKS];
	logic [RW-1:0]       r_ins [BANKS];
	logic [RW-1:0]       wdata [BANKS];
	logic [SW-1:0]       row_a [BANKS];
	logic [SW-1:0]       waddr [BANKS];
	logic                we [BANKS];
	bbtb_pkg::lane_res_t lres [BANKS];
	bbtb_pkg::lane_res_t r;
	bbtb_pkg::dec_t      dec;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? {26'd0, cap_q} : 32'd0;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tlast  = ol_q;
	assign fire     = (state_q == ST_RUN) && (!ov_q || m_tready);
	assign w0       = pc_q[63:2];
	assign ws       = w0 + WW'(pos_q);
	assign sel      = BIW'((b0_q + p_q) & BIW'(BANKS - 1));
	assign r        = lres[sel];
	assign dec      = bbtb_pkg::decode(insn_q, spc_q);

	always_comb begin
		init_row = '0;
		for (int i = 0; i < ASSOC; i++) init_row[i*EW+1 +: AW] = AW'(i);
	end

	for (genvar k = 0; k < BANKS; k++) begin : g_lane
		assign row_a[k] = SW'((w_s1[k] >> LB) & WW'(SETS - 1));
		assign waddr[k] = (state_q == ST_CLEAR) ? clr_q[SW-1:0] : row_a[k];

		bbtb_lane #(.ASSOC(ASSOC), .TW(TW)) u_lane (
			.row(rdata[k]),
			.tag(TW'(w_s1[k] >> (LB + LS))),
			.ins_kind(dec.kind),
			.ins_target(dec.target),
			.res(lres[k]),
			.row_touch(r_touch[k]),
			.row_clear(r_clear[k]),
			.row_ins(r_ins[k])
		);

		always_comb begin
			we[k] = 1'b0;
			wdata[k] = init_row;
			if (state_q == ST_CLEAR) begin
				we[k] = 1'b1;
			end else if (fire && sel == BIW'(k)) begin
				case (cmd_q)
					bbtb_pkg::CMD_LOOKUP: begin
						we[k] = lres[k].hit;
						wdata[k] = r_touch[k];
					end
					bbtb_pkg::CMD_INSTALL: begin
						we[k] = wr_ok;
						wdata[k] = r_ins[k];
					end
					default: begin
						we[k] = lres[k].hit;
						wdata[k] = r_clear[k];
					end
				endcase
			end
		end

		bbtb_ram #(.W(RW), .D(SETS)) u_ram (
			.clk(clk),
			.we(we[k]),
			.waddr(waddr[k]),
			.wdata(wdata[k]),
			.re(state_q == ST_READ),
			.raddr(row_a[k]),
			.rdata(rdata[k])
		);
	end

	// bundle merge for the current slot
	always_comb begin
		ncond_n = ncond_q;
		push_n = push_q;
		pop_n = pop_q;
		paddr_n = paddr_q;
		next_pc = spc_q + 64'd4;
		done = 1'b0;
		if (r.hit) begin
			case (r.kind)
				bbtb_pkg::KIND_COND: begin
					ncond_n = ncond_q + 5'd1;
					if (preds_q[1]) next_pc = r.target;
					if (preds_q[1] || {1'b0, ncond_n} == cap_q) done = 1'b1;
				end
				bbtb_pkg::KIND_JUMP, bbtb_pkg::KIND_CALL: begin
					next_pc = r.target;
					done = 1'b1;
				end
				bbtb_pkg::KIND_IJUMP, bbtb_pkg::KIND_ICALL: begin
					next_pc = ind_q;
					done = 1'b1;
				end
				default: begin
					next_pc = ret_q;
					done = 1'b1;
				end
			endcase
			if (r.kind == bbtb_pkg::KIND_CALL || r.kind == bbtb_pkg::KIND_ICALL) begin
				push_n = 1'b1;
				paddr_n = spc_q + 64'd4;
			end else if (r.kind == bbtb_pkg::KIND_RET) begin
				pop_n = 1'b1;
			end
		end
		if (exc_q[0]) done = 1'b1;
		if (p_q == BIW'(BANKS - 1)) done = 1'b1;
	end

	assign dup   = r.hit && r.kind == dec.kind && (dec.jalr || r.target == dec.target);
	assign wr_ok = dec.ok && !dup;

	always_comb begin
		od_n = '0;
		od_n[63:0] = spc_q;
		od_n[64] = r.hit;
		case (cmd_q)
			bbtb_pkg::CMD_LOOKUP: begin
				od_n[67:65] = r.hit ? r.kind : 3'd0;
				od_n[131:68] = r.hit ? r.target : 64'd0;
				od_n[195:132] = next_pc;
				if (done) begin
					od_n[199:196] = ncond_n[3:0];
					od_n[200] = push_n;
					od_n[264:201] = push_n ? paddr_n : 64'd0;
					od_n[265] = pop_n;
				end
			end
			bbtb_pkg::CMD_INSTALL: begin
				od_n[67:65] = dec.kind;
				od_n[131:68] = dec.target;
				od_n[266] = !wr_ok;
			end
			default: begin
				od_n[67:65] = r.hit ? r.kind : 3'd0;
				od_n[131:68] = r.hit ? r.target : 64'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 6'd3;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			cap_q <= pwdata[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
			ol_q <= 1'b0;
		end else begin
			if (fire) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid && s_tuser != bbtb_pkg::CMD_NOP) state_q <= ST_ADDR;
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_RUN;
				ST_RUN: begin
					if (fire) begin
						ol_q <= (cmd_q != bbtb_pkg::CMD_LOOKUP) || done;
						if (cmd_q != bbtb_pkg::CMD_LOOKUP || done) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q <= s_tuser;
			pc_q <= s_tdata[63:0];
			pos_q <= s_tdata[66:64];
			insn_q <= s_tdata[98:67];
			preds_q <= s_tdata[162:99];
			ind_q <= s_tdata[226:163];
			ret_q <= s_tdata[290:227];
			exc_q <= {8'd0, s_tdata[298:291]};
		end
		if (state_q == ST_ADDR) begin
			for (int k = 0; k < BANKS; k++) begin
				if (cmd_q == bbtb_pkg::CMD_LOOKUP)
					w_s1[k] <= w0 + WW'(BIW'((BIW'(k) - w0[BIW-1:0]) & BIW'(BANKS - 1)));
				else
					w_s1[k] <= ws;
			end
			b0_q <= (cmd_q == bbtb_pkg::CMD_LOOKUP) ? BIW'(w0 & WW'(BANKS - 1))
				: BIW'(ws & WW'(BANKS - 1));
			p_q <= '0;
			spc_q <= (cmd_q == bbtb_pkg::CMD_LOOKUP) ? pc_q
				: pc_q + {59'd0, pos_q, 2'b00};
			ncond_q <= '0;
			push_q <= 1'b0;
			pop_q <= 1'b0;
			paddr_q <= '0;
		end
		if (fire) begin
			od_q <= od_n;
			p_q <= p_q + 1'b1;
			spc_q <= spc_q + 64'd4;
			ncond_q <= ncond_n;
			push_q <= push_n;
			pop_q <= pop_n;
			paddr_q <= paddr_n;
			exc_q <= exc_q >> 1;
			if (r.hit && r.kind == bbtb_pkg::KIND_COND) preds_q <= preds_q >> 2;
		end
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !ov_q && !s_tready)
		else $error("activity during clearing pass");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_q != bbtb_pkg::CMD_LOOKUP |=> state_q == ST_IDLE && ol_q)
		else $error("install or invalidate did not end in one item");
	a_lastslot: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd_q == bbtb_pkg::CMD_LOOKUP && p_q == BIW'(BANKS - 1) |=> ol_q)
		else $error("bundle ran past the last bank");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_banked_branch_target_buffer.sv =====
// Self-checking testbench for banked_branch_target_buffer: directed table, then random
// lookups, installs and invalidates checked against an in-bench BTB predictor.
// Depends on bbtb_pkg and the RTL top level only.
`timescale 1ns / 1ps
module tb_banked_branch_target_buffer;

	localparam int NUM_ENT = 2048;
	localparam logic [2:0] REG_MAX_COND = 3'd0;

	typedef struct {
		logic [63:0] slot_pc;
		logic        is_branch;
		logic [2:0]  kind;
		logic [63:0] target;
		logic [63:0] next_pc;
		logic        last;
		logic [3:0]  cond_count;
		logic        push_ret;
		logic [63:0] push_addr;
		logic        pop_ret;
		logic        err;
	} slot_res_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] pc;
		logic [2:0]  slot;
		logic [31:0] insn;
		logic [63:0] preds;
		logic [63:0] ind;
		logic [63:0] ret;
		logic [7:0]  exc;
		bit          lit;
		bit          lit_hit;
		bit          lit_err;
	} stim_row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [303:0] s_tdata;
	logic [1:0] s_tuser;
	logic [271:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	banked_branch_target_buffer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	bit          btb_valid[NUM_ENT];
	logic [52:0] btb_tag[NUM_ENT];
	logic [1:0]  btb_age[NUM_ENT];
	logic [2:0]  btb_kind[NUM_ENT];
	logic [63:0] btb_tgt[NUM_ENT];
	logic [5:0]  cond_cap;

	slot_res_t   pending_q[$];
	int          n_fail, n_results, n_items, n_hits, n_errs, cycles;
	logic [63:0] pc_pool[10];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stall pattern: the mode follows bits 7:6 of the cycle counter
	always @(posedge clk) begin
		case (cycles[7:6])
			2'd0: begin
				m_tready <= 1'b1;
			end
			2'd1: begin
				m_tready <= ($urandom_range(3) != 0);
			end
			2'd2: begin
				m_tready <= (cycles[3:0] < 4'd5);
			end
			default: begin
				m_tready <= 1'($urandom_range(1));
			end
		endcase
	end

	function automatic int set_base(input logic [63:0] spc, output logic [52:0] tag);
		logic [61:0] w;
		w = spc[63:2];
		tag = w[61:9];
		return (int'(w[2:0]) * 64 + int'(w[8:3])) * 4;
	endfunction

	function automatic bit find_way(input int base, input logic [52:0] tag, output int way);
		int lru;
		lru = 0;
		for (int i = 0; i < 4; i++) begin
			if (btb_valid[base + i] && btb_tag[base + i] == tag) begin
				way = i;
				return 1'b1;
			end
			if (btb_age[base + i] == 2'd3) lru = i;
		end
		way = lru;
		return 1'b0;
	endfunction

	function automatic void make_mru(input int base, input int way);
		logic [1:0] a;
		a = btb_age[base + way];
		for (int i = 0; i < 4; i++)
			if (btb_age[base + i] < a) btb_age[base + i]++;
		btb_age[base + way] = 2'd0;
	endfunction

	// returns 0 when the word is not a branch or jump
	function automatic bit decode_branch(input logic [31:0] w, input logic [63:0] pc,
			output logic [2:0] kind, output logic [63:0] tgt);
		kind = bbtb_pkg::KIND_COND;
		tgt = '0;
		case (w[6:0])
			bbtb_pkg::OPC_BRANCH: begin
				tgt = pc + {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
			end
			bbtb_pkg::OPC_JAL: begin
				kind = (w[11:7] == 5'd1) ? bbtb_pkg::KIND_CALL : bbtb_pkg::KIND_JUMP;
				tgt = pc + {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			bbtb_pkg::OPC_JALR: begin
				if (w[11:7] == 5'd0 && w[19:15] == 5'd1) kind = bbtb_pkg::KIND_RET;
				else if (w[11:7] == 5'd1) kind = bbtb_pkg::KIND_ICALL;
				else kind = bbtb_pkg::KIND_IJUMP;
			end
			default: begin
				return 1'b0;
			end
		endcase
		return 1'b1;
	endfunction

	task automatic predict_item(input stim_row_t r);
		slot_res_t o;
		logic [52:0] tag;
		logic [63:0] preds, tgt;
		logic [2:0] k;
		int base, way, ncond, bundle_start;
		bit hit, done, taken, ok;
		logic [1:0] a;
		ncond = 0;
		done = 0;
		preds = r.preds;
		n_items++;
		if (r.cmd == bbtb_pkg::CMD_NOP) return;
		if (r.cmd == bbtb_pkg::CMD_LOOKUP) begin
			bundle_start = pending_q.size();
			for (int p = 0; p < 8 && !done; p++) begin
				o = '{default: '0};
				o.slot_pc = r.pc + 64'(p * 4);
				o.next_pc = o.slot_pc + 64'd4;
				base = set_base(o.slot_pc, tag);
				hit = find_way(base, tag, way);
				o.is_branch = hit;
				if (hit) begin
					n_hits++;
					o.kind = btb_kind[base + way];
					o.target = btb_tgt[base + way];
					make_mru(base, way);
					done = 1;
					case (o.kind)
						bbtb_pkg::KIND_COND: begin
							taken = (preds[1:0] >= 2'd2);
							preds = preds >> 2;
							ncond++;
							if (taken) o.next_pc = o.target;
							done = taken || (ncond == int'(cond_cap));
						end
						bbtb_pkg::KIND_JUMP, bbtb_pkg::KIND_CALL: o.next_pc = o.target;
						bbtb_pkg::KIND_IJUMP, bbtb_pkg::KIND_ICALL: o.next_pc = r.ind;
						default: o.next_pc = r.ret;
					endcase
					if (o.kind == bbtb_pkg::KIND_CALL || o.kind == bbtb_pkg::KIND_ICALL) begin
						o.push_ret = 1'b1;
						o.push_addr = o.slot_pc + 64'd4;
					end else if (o.kind == bbtb_pkg::KIND_RET) begin
						o.pop_ret = 1'b1;
					end
				end
				if (r.exc[p]) done = 1;
				pending_q.push_back(o);
			end
			// bundle summary rides on the last slot only
			o = pending_q.pop_back();
			o.last = 1'b1;
			o.cond_count = 4'(ncond);
			for (int i = bundle_start; i < pending_q.size(); i++) begin
				if (pending_q[i].push_ret) begin
					o.push_ret = 1'b1;
					o.push_addr = pending_q[i].push_addr;
				end
				if (pending_q[i].pop_ret) o.pop_ret = 1'b1;
				pending_q[i].push_ret = 1'b0;
				pending_q[i].push_addr = '0;
				pending_q[i].pop_ret = 1'b0;
			end
			pending_q.push_back(o);
			return;
		end
		o = '{default: '0};
		o.slot_pc = r.pc + {59'd0, r.slot, 2'b00};
		o.last = 1'b1;
		base = set_base(o.slot_pc, tag);
		hit = find_way(base, tag, way);
		o.is_branch = hit;
		if (r.cmd == bbtb_pkg::CMD_INSTALL) begin
			ok = decode_branch(r.insn, o.slot_pc, k, tgt);
			if (!ok) begin
				o.err = 1'b1;
			end else begin
				o.kind = k;
				o.target = tgt;
				if (hit && btb_kind[base + way] == k
						&& (r.insn[6:0] == bbtb_pkg::OPC_JALR || btb_tgt[base + way] == tgt)) begin
					o.err = 1'b1;
				end else begin
					btb_valid[base + way] = 1'b1;
					btb_tag[base + way] = tag;
					make_mru(base, way);
					btb_kind[base + way] = k;
					btb_tgt[base + way] = tgt;
				end
			end
			if (o.err) n_errs++;
		end else if (hit) begin
			a = btb_age[base + way];
			o.kind = btb_kind[base + way];
			o.target = btb_tgt[base + way];
			btb_valid[base + way] = 1'b0;
			for (int i = 0; i < 4; i++)
				if (btb_age[base + i] > a) btb_age[base + i]--;
			btb_age[base + way] = 2'd3;
		end
		if (r.lit) begin
			o.is_branch = r.lit_hit;
			o.err = r.lit_err;
		end
		pending_q.push_back(o);
	endtask

	// result checker
	always @(posedge clk) begin
		slot_res_t e;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$error("result item with nothing expected");
				n_fail++;
			end else begin
				e = pending_q.pop_front();
				if (m_tdata[63:0] !== e.slot_pc) begin
					$error("slot_pc exp %h got %h", e.slot_pc, m_tdata[63:0]); n_fail++;
				end
				if (m_tdata[64] !== e.is_branch) begin
					$error("is_branch exp %b got %b", e.is_branch, m_tdata[64]); n_fail++;
				end
				if (m_tdata[67:65] !== e.kind) begin
					$error("branch_kind exp %0d got %0d", e.kind, m_tdata[67:65]); n_fail++;
				end
				if (m_tdata[131:68] !== e.target) begin
					$error("stored_target exp %h got %h", e.target, m_tdata[131:68]); n_fail++;
				end
				if (m_tdata[195:132] !== e.next_pc) begin
					$error("slot_next_pc exp %h got %h", e.next_pc, m_tdata[195:132]); n_fail++;
				end
				if (m_tlast !== e.last) begin
					$error("last exp %b got %b", e.last, m_tlast); n_fail++;
				end
				if (m_tdata[199:196] !== e.cond_count) begin
					$error("cond_count exp %0d got %0d", e.cond_count, m_tdata[199:196]);
					n_fail++;
				end
				if (m_tdata[200] !== e.push_ret) begin
					$error("push_return exp %b got %b", e.push_ret, m_tdata[200]); n_fail++;
				end
				if (m_tdata[264:201] !== e.push_addr) begin
					$error("push_address exp %h got %h", e.push_addr, m_tdata[264:201]);
					n_fail++;
				end
				if (m_tdata[265] !== e.pop_ret) begin
					$error("pop_return exp %b got %b", e.pop_ret, m_tdata[265]); n_fail++;
				end
				if (m_tdata[266] !== e.err) begin
					$error("error_flag exp %b got %b", e.err, m_tdata[266]); n_fail++;
				end
			end
		end
	end

	// called at a rising edge; leaves s_tvalid high after the accept
	task automatic send_item(input stim_row_t r);
		s_tuser <= r.cmd;
		s_tdata <= {5'd0, r.exc, r.ret, r.ind, r.preds, r.insn, r.slot, r.pc};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_item(r);
	endtask

	task automatic write_cap(input logic [5:0] val);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_MAX_COND;
		pwdata <= {26'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cond_cap = val;
		@(posedge clk);
		if (prdata[5:0] !== val) begin
			$error("max_cond_branches readback exp %0d got %0d", val, prdata[5:0]);
			n_fail++;
		end
	endtask

	function automatic logic [31:0] rand_insn();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0, 1, 2: w[6:0] = bbtb_pkg::OPC_BRANCH;
			3, 4, 5: w[6:0] = bbtb_pkg::OPC_JAL;
			6, 7, 8: w[6:0] = bbtb_pkg::OPC_JALR;
			default: ;
		endcase
		case ($urandom_range(2))
			0: w[11:7] = 5'd0;
			1: w[11:7] = 5'd1;
			default: ;
		endcase
		if ($urandom_range(1)) w[19:15] = 5'd1;
		return w;
	endfunction

	stim_row_t dir_tab[20];

	initial begin
		stim_row_t r;
		int burst, gap, sel;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bbtb_pkg::CMD_LOOKUP;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		n_fail = 0; n_results = 0; n_items = 0; n_hits = 0; n_errs = 0;
		cond_cap = 6'd3;
		for (int i = 0; i < NUM_ENT; i++) begin
			btb_valid[i] = 1'b0;
			btb_age[i] = 2'(i % 4);
			btb_tag[i] = '0;
			btb_kind[i] = bbtb_pkg::KIND_COND;
			btb_tgt[i] = '0;
		end
		//            cmd          pc                     slot insn          preds
		//            ind                    ret                    exc  lit hit err
		dir_tab[0]  = '{bbtb_pkg::CMD_LOOKUP, 64'h0, 3'd0, 32'h0, 64'h0,
			64'h0, 64'h0, 8'h00, 1, 0, 0};
		dir_tab[1]  = '{bbtb_pkg::CMD_INSTALL, 64'h100, 3'd0, 32'h00000013, 64'h0,
			64'h0, 64'h0, 8'h00, 1, 0, 1};
		dir_tab[2]  = '{bbtb_pkg::CMD_INSTALL, 64'h100, 3'd0, 32'hfe000ee3, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[3]  = '{bbtb_pkg::CMD_INSTALL, 64'h100, 3'd1, 32'h7e000fe3, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[4]  = '{bbtb_pkg::CMD_INSTALL, 64'h100, 3'd2, 32'h800000ef, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[5]  = '{bbtb_pkg::CMD_LOOKUP, 64'h100, 3'd0, 32'h0, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[6]  = '{bbtb_pkg::CMD_LOOKUP, 64'h100, 3'd0, 32'h0, 64'hffffffffffffffff,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[7]  = '{bbtb_pkg::CMD_INSTALL, 64'h200, 3'd7, 32'h7ffff06f, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[8]  = '{bbtb_pkg::CMD_INSTALL, 64'h200, 3'd3, 32'h00008067, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[9]  = '{bbtb_pkg::CMD_INSTALL, 64'h200, 3'd3, 32'h00008067, 64'h0,
			64'h0, 64'h0, 8'h00, 1, 1, 1};
		dir_tab[10] = '{bbtb_pkg::CMD_INSTALL, 64'h200, 3'd1, 32'h000080e7, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[11] = '{bbtb_pkg::CMD_INSTALL, 64'h200, 3'd2, 32'h00028067, 64'h0,
			64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[12] = '{bbtb_pkg::CMD_LOOKUP, 64'h200, 3'd0, 32'h0, 64'h0,
			64'hffffffffffffffff, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[13] = '{bbtb_pkg::CMD_INVAL, 64'h200, 3'd1, 32'h0, 64'h0,
			64'h0, 64'h0, 8'h00, 1, 1, 0};
		dir_tab[14] = '{bbtb_pkg::CMD_INVAL, 64'h200, 3'd1, 32'h0, 64'h0,
			64'h0, 64'h0, 8'h00, 1, 0, 0};
		dir_tab[15] = '{bbtb_pkg::CMD_LOOKUP, 64'h200, 3'd0, 32'h0, 64'h0,
			64'h0, 64'haaaaaaaaaaaaaaaa, 8'h00, 0, 0, 0};
		dir_tab[16] = '{bbtb_pkg::CMD_NOP, 64'h200, 3'd0, 32'h00008067, 64'h0,
			64'h0, 64'h0, 8'hff, 0, 0, 0};
		dir_tab[17] = '{bbtb_pkg::CMD_INSTALL, 64'hfffffffffffffff8, 3'd3, 32'h0000006f,
			64'h0, 64'h0, 64'h0, 8'h00, 0, 0, 0};
		dir_tab[18] = '{bbtb_pkg::CMD_LOOKUP, 64'hfffffffffffffff8, 3'd0, 32'h0, 64'h0,
			64'h0, 64'h0, 8'h80, 0, 0, 0};
		dir_tab[19] = '{bbtb_pkg::CMD_LOOKUP, 64'h100, 3'd0, 32'h0, 64'h0,
			64'h0, 64'h0, 8'hff, 0, 0, 0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		foreach (dir_tab[i]) send_item(dir_tab[i]);

		pc_pool[0] = 64'h1000;
		pc_pool[1] = 64'h1000 + 64'd2048;
		pc_pool[2] = 64'h1000 + 64'd4096;
		pc_pool[3] = 64'h1000 + 64'd6144;
		pc_pool[4] = 64'h1000 + 64'd8192;
		pc_pool[5] = 64'hffffffffffffffe4;
		for (int i = 6; i < 10; i++) pc_pool[i] = {$urandom, $urandom};

		burst = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_cap(6'd1);
				1: write_cap(6'd32);
				2: write_cap(6'd63);
				3: write_cap(6'd0);
				default: write_cap(6'($urandom_range(2, 5)));
			endcase
			@(posedge clk);
			for (int n = 0; n < 60; n++) begin
				sel = $urandom_range(99);
				r.cmd = (sel < 45) ? bbtb_pkg::CMD_LOOKUP : (sel < 80) ? bbtb_pkg::CMD_INSTALL
					: (sel < 95) ? bbtb_pkg::CMD_INVAL : bbtb_pkg::CMD_NOP;
				r.pc = pc_pool[$urandom_range(9)];
				if ($urandom_range(9) == 0) r.pc = {$urandom, $urandom};
				r.slot = 3'($urandom_range(7));
				r.insn = rand_insn();
				r.preds = {$urandom, $urandom};
				r.ind = {$urandom, $urandom};
				r.ret = {$urandom, $urandom};
				r.exc = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
				r.lit = 0; r.lit_hit = 0; r.lit_err = 0;
				send_item(r);
				if (burst == 0) begin
					burst = $urandom_range(12);
					gap = (ph == 2) ? 0 : $urandom_range(6);
					if (gap != 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end else begin
					burst--;
				end
			end
		end
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d items (%0d results, %0d slot hits, %0d rejected installs)",
			n_items, n_results, n_hits, n_errs);
		$display("over five bundle cap settings with random sender gaps and receiver stalls");
		if (n_fail == 0 && pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== banked_branch_target_buffer.f =====
rtl/core/bbtb_pkg.sv
rtl/core/bbtb_ram.sv
rtl/core/bbtb_lane.sv
rtl/core/banked_branch_target_buffer.sv
verif/tb_banked_branch_target_buffer.sv
